FILE: rtl/bia_pkg.sv
// Shared types, constants and helpers for the bitmap identifier allocator.
`timescale 1ns / 1ps
package bia_pkg;

   localparam int ID_W             = 16;
   localparam int BYTE_W           = 8;
   localparam int BIT_IDX_W        = 3;
   localparam int DEF_BITMAP_BYTES = 32;
   localparam int MAX_BITMAP_BYTES = 1024;
   // width of the byte index of an offset inside the 16-bit id space
   localparam int OFS_BYTE_W       = ID_W - BIT_IDX_W;

   localparam logic [BYTE_W-1:0] BYTE_FULL     = 8'hff;
   localparam logic [ID_W-1:0]   BASE_ID_RESET = 16'd1;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_CHK,
      ST_REL_WR,
      ST_DONE
   } state_type;

   // address bits for a bitmap of n bytes (at least one bit)
   function automatic int addr_bits(input int n);
      int w;
      begin
         w = (n > 1) ? $clog2(n) : 1;
         return w;
      end
   endfunction

   // lowest clear bit; 7 when the byte is full (caller checks for full)
   function automatic logic [BIT_IDX_W-1:0] first_clear(input logic [BYTE_W-1:0] v);
      logic [BIT_IDX_W-1:0] b;
      begin
         b = 3'd7;
         for (int i = BYTE_W - 2; i >= 0; i--) begin
            if (!v[i]) b = BIT_IDX_W'(i);
         end
         return b;
      end
   endfunction

endpackage

FILE: rtl/bia_ifs.sv
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps
interface bia_req_if;
   import bia_pkg::*;
   logic            valid;
   logic            ready;
   logic            mode;
   logic [ID_W-1:0] id;
   modport source (output valid, output mode, output id, input ready);
   modport sink   (input valid, input mode, input id, output ready);
endinterface

interface bia_rsp_if;
   import bia_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] alloc_id;
   logic            failed;
   modport source (output valid, output alloc_id, output failed, input ready);
   modport sink   (input valid, input alloc_id, input failed, output ready);
endinterface

interface bia_csr_if;
   import bia_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bia_bitmap_ram.sv
// Used-bit bitmap storage: one write port, one registered read port.
`timescale 1ns / 1ps
module bia_bitmap_ram #(
   parameter int  BITMAP_BYTES = bia_pkg::DEF_BITMAP_BYTES,
   localparam int AW           = bia_pkg::addr_bits(BITMAP_BYTES)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bia_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [bia_pkg::BYTE_W-1:0] rd_data
);
   import bia_pkg::*;

   logic [BYTE_W-1:0] mem [BITMAP_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bitmap_id_allocator_core.sv
// Top level: first-free identifier allocator over a used-bit bitmap in RAM.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake      Payload
//  req_bus   in   valid/ready    mode (0 alloc, 1 release), id[15:0]
//  rsp_bus   out  valid/ready    alloc_id[15:0], failed
//  csr_bus   in   valid/ready    data[15:0] -> base_id (reset 1)
//
//  Allocate: one bitmap byte read per cycle from the single RAM read port,
//  through the registered read and a result stage, up to BITMAP_BYTES bytes;
//  release reads the byte and writes it back, and an out-of-range release
//  skips the write.
//  Reset: a clearing pass writes zero to every bitmap byte, during which
//  req_bus.ready stays low.
//  Stalls: one request is in flight at a time; the response register lets the
//  next request be accepted while the previous response is still held.
//
module bitmap_id_allocator_core #(
   parameter int BITMAP_BYTES = bia_pkg::DEF_BITMAP_BYTES
) (
   input  logic  clock,
   input  logic  reset,
   bia_req_if.sink   req_bus,
   bia_rsp_if.source rsp_bus,
   bia_csr_if.sink   csr_bus
);
   import bia_pkg::*;

   localparam int AW = addr_bits(BITMAP_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);

   state_type state_ff, state_in;

   logic [ID_W-1:0]      base_id_ff;
   logic [AW-1:0]        scan_addr_ff;   // also the clear-pass counter
   logic [AW-1:0]        chk_addr_ff;    // address of the byte now in rd_data
   logic                 chk_vld_ff;
   logic [ID_W-1:0]      req_id_ff;
   logic [AW-1:0]        rel_addr_ff;
   logic [BIT_IDX_W-1:0] rel_bit_ff;
   logic [ID_W-1:0]      res_id_ff;
   logic                 res_fail_ff;
   logic                 rsp_vld_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic                 rsp_fail_ff;

   // RAM port signals
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   logic                 req_acc;
   logic                 slot_free;
   logic                 scan_found;
   logic                 scan_end;
   logic [BIT_IDX_W-1:0] scan_bit;
   logic [ID_W-1:0]      scan_id;
   logic [ID_W:0]        rel_diff;
   logic                 rel_bad;

   bia_bitmap_ram #(
      .BITMAP_BYTES (BITMAP_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------
   // Datapath decode
   // ---------------------------------------------------------------
   assign req_acc   = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_vld_ff || rsp_bus.ready;

   // scan: byte chk_addr_ff is on the read data this cycle
   assign scan_found = chk_vld_ff && (mem_rd_data != BYTE_FULL);
   assign scan_end   = chk_vld_ff && (chk_addr_ff == LAST_ADDR);
   assign scan_bit   = first_clear(mem_rd_data);
   // base + 8*byte + bit, wraps mod 2^16
   assign scan_id    = base_id_ff + ID_W'({chk_addr_ff, scan_bit});

   // release: offset = id - base; sign bit set means id below base
   assign rel_diff = {1'b0, req_id_ff} - {1'b0, base_id_ff};
   assign rel_bad  = rel_diff[ID_W] ||
                     (rel_diff[ID_W-1:BIT_IDX_W] >= OFS_BYTE_W'(BITMAP_BYTES));

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_bus.mode == MODE_RELEASE) ? ST_REL_CHK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_found || scan_end) state_in = ST_DONE;
         end
         ST_REL_CHK: begin
            state_in = rel_bad ? ST_DONE : ST_REL_WR;
         end
         ST_REL_WR: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------
   // Outputs of the state machine: RAM ports and ready
   // ---------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = scan_addr_ff;
      mem_wr_data   = '0;
      mem_rd_addr   = scan_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_SCAN: begin
            // set the first clear bit of the first non-full byte
            mem_wr_en   = scan_found;
            mem_wr_addr = chk_addr_ff;
            mem_wr_data = mem_rd_data | (BYTE_W'(1) << scan_bit);
         end
         ST_REL_CHK: begin
            mem_rd_addr = rel_diff[AW+BIT_IDX_W-1:BIT_IDX_W];
         end
         ST_REL_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rel_addr_ff;
            mem_wr_data = mem_rd_data & ~(BYTE_W'(1) << rel_bit_ff);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_id_ff   <= BASE_ID_RESET;
         scan_addr_ff <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_bus.valid && csr_bus.ready) base_id_ff <= csr_bus.data;

         unique case (state_ff)
            ST_CLEAR: begin
               if (scan_addr_ff != LAST_ADDR) scan_addr_ff <= scan_addr_ff + AW'(1);
            end
            ST_IDLE: begin
               scan_addr_ff <= '0;
               chk_vld_ff   <= 1'b0;
            end
            ST_SCAN: begin
               if (!scan_found && !scan_end) begin
                  chk_addr_ff <= scan_addr_ff;
                  chk_vld_ff  <= 1'b1;
                  if (scan_addr_ff != LAST_ADDR) scan_addr_ff <= scan_addr_ff + AW'(1);
               end
            end
            default: begin
            end
         endcase

         if (rsp_vld_ff && rsp_bus.ready) rsp_vld_ff <= 1'b0;
         if (state_ff == ST_DONE && slot_free) rsp_vld_ff <= 1'b1;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_acc) req_id_ff <= req_bus.id;

      if (state_ff == ST_REL_CHK) begin
         rel_addr_ff <= rel_diff[AW+BIT_IDX_W-1:BIT_IDX_W];
         rel_bit_ff  <= rel_diff[BIT_IDX_W-1:0];
      end

      if (state_ff == ST_SCAN) begin
         res_id_ff   <= scan_found ? scan_id : '0;
         res_fail_ff <= !scan_found;
      end else if (state_ff == ST_REL_CHK) begin
         res_id_ff   <= '0;
         res_fail_ff <= rel_bad;
      end

      if (state_ff == ST_DONE && slot_free) begin
         rsp_id_ff   <= res_id_ff;
         rsp_fail_ff <= res_fail_ff;
      end
   end

   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_vld_ff;
   assign rsp_bus.alloc_id = rsp_id_ff;
   assign rsp_bus.failed   = rsp_fail_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("reset did not start the clearing pass");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !mem_wr_en)
      else $error("bitmap written outside an operation");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_SCAN || state_ff == ST_REL_CHK))
      else $error("accepted request did not start an operation");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_found) |=> (state_ff == ST_DONE && !res_fail_ff))
      else $error("free bit found but allocation not reported good");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the result stage");

endmodule

FILE: tb/sv/bitmap_id_allocator_core_tb.sv
// Testbench for the bitmap identifier allocator: random-stall driving and scoreboard checks.
`timescale 1ns / 1ps
module bitmap_id_allocator_core_tb;
   import bia_pkg::*;

   localparam int MAP_BYTES   = DEF_BITMAP_BYTES;
   localparam int MAP_IDS     = MAP_BYTES * BYTE_W;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [ID_W-1:0] alloc_id;
      logic            failed;
   } alloc_result_type;

   // Shadow bitmap plus the queue of responses still owed by the block.
   class alloc_scoreboard;
      bit [BYTE_W-1:0]  used_map [MAP_BYTES];
      logic [ID_W-1:0]  base_id = BASE_ID_RESET;
      alloc_result_type expected_results[$];
      int errors      = 0;
      int n_requests  = 0;
      int n_granted   = 0;
      int n_full      = 0;
      int n_wrapped   = 0;
      int n_released  = 0;
      int n_rejected  = 0;

      function void note_base(logic [ID_W-1:0] value);
         base_id = value;
      endfunction

      function void note_request(logic mode, logic [ID_W-1:0] id);
         alloc_result_type res;
         int               offset;
         int               sum;
         bit               done;
         res    = '0;
         done   = 1'b0;
         n_requests++;
         if (mode == MODE_ALLOC) begin
            for (int i = 0; i < MAP_BYTES && !done; i++) begin
               if (used_map[i] != BYTE_FULL) begin
                  for (int b = 0; b < BYTE_W && !done; b++) begin
                     if (!used_map[i][b]) begin
                        used_map[i][b] = 1'b1;
                        sum            = int'(base_id) + i * BYTE_W + b;
                        res.alloc_id   = sum[ID_W-1:0];
                        done           = 1'b1;
                     end
                  end
               end
            end
            res.failed = !done;
            if (done) begin
               n_granted++;
               if (res.alloc_id < base_id) n_wrapped++;
            end else begin
               n_full++;
            end
         end else begin
            offset = int'(id) - int'(base_id);
            if (id < base_id || offset >= MAP_IDS) begin
               res.failed = 1'b1;
               n_rejected++;
            end else begin
               used_map[offset / BYTE_W][offset % BYTE_W] = 1'b0;
               n_released++;
            end
         end
         expected_results.push_back(res);
      endfunction

      function void check_response(logic [ID_W-1:0] got_id, logic got_failed);
         alloc_result_type want;
         if (expected_results.size() == 0) begin
            $error("response with nothing outstanding: alloc_id %h failed %b",
                   got_id, got_failed);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (got_id !== want.alloc_id) begin
            $error("alloc_id: expected %h, got %h", want.alloc_id, got_id);
            errors++;
         end
         if (got_failed !== want.failed) begin
            $error("failed: expected %b, got %b", want.failed, got_failed);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // random offset whose bit is currently set, -1 when the map is empty
      function int pick_used_offset();
         int count;
         int k;
         count = 0;
         for (int o = 0; o < MAP_IDS; o++)
            if (used_map[o / BYTE_W][o % BYTE_W]) count++;
         if (count == 0) return -1;
         k = $urandom_range(0, count - 1);
         for (int o = 0; o < MAP_IDS; o++) begin
            if (used_map[o / BYTE_W][o % BYTE_W]) begin
               if (k == 0) return o;
               k--;
            end
         end
         return -1;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   bit   idle_on = 1'b1;

   alloc_scoreboard sb;

   bia_req_if req_bus();
   bia_rsp_if rsp_bus();
   bia_csr_if csr_bus();

   bitmap_id_allocator_core #(
      .BITMAP_BYTES(MAP_BYTES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // One request per call; called at a clock edge, returns at the accepting edge.
   task automatic send_request(logic mode, logic [ID_W-1:0] id);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.id    <= id;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(mode, id);
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // base_id write; only issued with the block idle
   task automatic write_base(logic [ID_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.note_base(value);
      csr_bus.valid <= 1'b0;
   endtask

   // Random phase: alloc_pct percent allocations, releases mostly of live ids.
   task automatic run_phase(logic [ID_W-1:0] base, int items, int alloc_pct, bit idle);
      int              r;
      int              off;
      logic [ID_W-1:0] rel_id;
      write_base(base);
      idle_on = idle;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < alloc_pct) begin
            send_request(MODE_ALLOC, ID_W'($urandom));
         end else begin
            r   = $urandom_range(0, 99);
            off = sb.pick_used_offset();
            if (r < 60 && off >= 0)
               rel_id = ID_W'(int'(sb.base_id) + off);
            else if (r < 85)
               rel_id = ID_W'(int'(sb.base_id) + $urandom_range(0, MAP_IDS + 7));
            else
               rel_id = ID_W'($urandom);
            send_request(MODE_RELEASE, rel_id);
         end
      end
      drain();
      idle_on = 1'b1;
   endtask

   // Response side: random back-pressure, every accepted response is checked.
   initial begin : rsp_side
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_response(rsp_bus.alloc_id, rsp_bus.failed);
      end
   end

   initial begin : stimulus
      sb = new;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode  <= MODE_ALLOC;
      req_bus.id    <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: first-free order, reuse of a released id, releases below the
      // base, past the capacity, at the last slot, of a free id.
      send_request(MODE_ALLOC, 16'hffff);
      send_request(MODE_ALLOC, 16'h0000);
      send_request(MODE_ALLOC, 16'h5a5a);
      send_request(MODE_RELEASE, 16'd2);
      send_request(MODE_ALLOC, 16'h0000);
      send_request(MODE_RELEASE, 16'd0);
      send_request(MODE_RELEASE, 16'hffff);
      send_request(MODE_RELEASE, 16'd256);
      send_request(MODE_RELEASE, 16'd257);
      send_request(MODE_RELEASE, 16'd3);
      send_request(MODE_RELEASE, 16'd3);
      drain();

      // base 0: clear the low slots so the wrap test starts from offset 0
      write_base(16'h0000);
      send_request(MODE_RELEASE, 16'd0);
      send_request(MODE_RELEASE, 16'd1);
      send_request(MODE_RELEASE, 16'hffff);
      send_request(MODE_RELEASE, 16'd255);
      drain();

      // base at the top: second allocation wraps to id 0 with failed low
      write_base(16'hffff);
      send_request(MODE_ALLOC, 16'h1234);
      send_request(MODE_ALLOC, 16'h0000);
      send_request(MODE_RELEASE, 16'h0000);
      send_request(MODE_RELEASE, 16'hffff);
      drain();

      // Random: fill the map, run it full, drain it, then wrap near the top.
      run_phase(16'd1, 160, 95, 1'b1);
      run_phase(16'hfeff, 130, 90, 1'b1);
      run_phase(ID_W'($urandom_range(0, 16'hfeff)), 90, 25, 1'b0);
      run_phase(16'hff80, 70, 70, 1'b1);
      run_phase(16'h0000, 50, 50, 1'b1);

      repeat (MAP_BYTES + 8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.errors++;
      end

      $display("Ran %0d requests: %0d ids granted (%0d wrapped past 0xffff), %0d refused full,",
               sb.n_requests, sb.n_granted, sb.n_wrapped, sb.n_full);
      $display("  %0d releases applied, %0d rejected as out of range; 7 base_id settings.",
               sb.n_released, sb.n_rejected);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bia_pkg.sv
rtl/bia_ifs.sv
rtl/bia_bitmap_ram.sv
rtl/bitmap_id_allocator_core.sv
tb/sv/bitmap_id_allocator_core_tb.sv
